// ===== hw/rtl/mdi_pkg.sv =====
`default_nettype none

package mdi_pkg;

    // Width of the payload fields on the ports
    localparam int FIELD_W = 32;
    // Working width of the arithmetic (operands are taken to this many bits)
    localparam int WIDTH   = 32;
    localparam int CNT_W   = $clog2(WIDTH);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_COPRIME = 2'd1,
        ST_BAD_MODULUS = 2'd2
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] modulus;
    } operands_t;

    typedef struct packed {
        logic [FIELD_W-1:0] inverse_out;
        status_t            status;
    } result_t;

    // Bezout coefficient, magnitude never above the modulus
    typedef logic signed [WIDTH:0]   coef_t;
    // Quotient times coefficient, magnitude never above twice the modulus
    typedef logic signed [WIDTH+1:0] prod_t;

    typedef struct packed {
        logic             go;
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        coef_t            coef;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic [WIDTH-1:0] rem;
        prod_t            prod;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mdi_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first. Each quotient
// bit also folds the coefficient into a Horner accumulator so that the
// product quotient * coef is ready together with the remainder.
module mdi_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mdi_pkg::div_req_t req,
    output mdi_pkg::div_rsp_t      rsp
);

    logic [mdi_pkg::CNT_W-1:0] cnt_reg;
    logic                      active_reg;
    logic                      done_reg;
    logic [mdi_pkg::WIDTH-1:0] rem_reg;
    logic [mdi_pkg::WIDTH-1:0] dvd_reg;
    logic [mdi_pkg::WIDTH-1:0] dvs_reg;
    mdi_pkg::coef_t            coef_reg;
    mdi_pkg::prod_t            acc_reg;

    logic [mdi_pkg::WIDTH:0]   trial;
    logic [mdi_pkg::WIDTH:0]   diff;
    logic                      fits;
    logic [mdi_pkg::WIDTH-1:0] rem_step;
    mdi_pkg::prod_t            acc_step;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[mdi_pkg::WIDTH-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_step = fits ? diff[mdi_pkg::WIDTH-1:0] : trial[mdi_pkg::WIDTH-1:0];
        acc_step = (acc_reg <<< 1) + (fits ? mdi_pkg::prod_t'(coef_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                cnt_reg    <= mdi_pkg::CNT_W'(mdi_pkg::WIDTH - 1);
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            rem_reg  <= '0;
            dvd_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            coef_reg <= req.coef;
            acc_reg  <= '0;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[mdi_pkg::WIDTH-2:0], 1'b0};
            acc_reg <= acc_step;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = active_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/modular_inverse_unit.sv =====
`default_nettype none

// Modular inverse by the extended Euclidean algorithm.
//
// Input channel: drive operands (value, modulus) and raise start; the beat
// is taken at the rising edge where start is high and busy is low. busy
// stays high while the item is being worked on.
// Output channel: the result beat (inverse_out, status) appears on result
// for exactly one cycle with done high. The receiver cannot stall it, so
// capture it on that cycle; it is not repeated.
// Status: ok, not coprime (inverse 0), or modulus below 2 (inverse 0).
//
// Timing: a modulus below 2 is answered the cycle after the beat, with
// busy staying low. Otherwise one division reduces value modulo modulus,
// then each Euclid round is one further division. The shared divider
// produces one quotient bit per cycle, and the result is reported once a
// division leaves a zero remainder. One item is in flight at a time.
//
// Reset clears the sequencer and the strobes; no result is pending after it.
module modular_inverse_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mdi_pkg::operands_t operands,
    output logic                    done,
    output mdi_pkg::result_t        result
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REDUCE = 3'b010,
        S_ROUND  = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic                      done_reg, done_next;
    mdi_pkg::result_t          result_reg, result_next;
    logic [mdi_pkg::WIDTH-1:0] m_reg, m_next;
    logic [mdi_pkg::WIDTH-1:0] r_prev_reg, r_prev_next;
    logic [mdi_pkg::WIDTH-1:0] r_cur_reg, r_cur_next;
    mdi_pkg::coef_t            c_prev_reg, c_prev_next;
    mdi_pkg::coef_t            c_cur_reg, c_cur_next;

    mdi_pkg::div_req_t         div_req;
    mdi_pkg::div_rsp_t         div_rsp;

    logic [mdi_pkg::WIDTH-1:0] val_w;
    logic [mdi_pkg::WIDTH-1:0] mod_w;
    logic                      accept;
    mdi_pkg::coef_t            c_new;
    logic [mdi_pkg::WIDTH-1:0] fin_r;
    mdi_pkg::coef_t            fin_c;
    mdi_pkg::coef_t            fin_fix;

    mdi_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        val_w  = mdi_pkg::WIDTH'(operands.value);
        mod_w  = mdi_pkg::WIDTH'(operands.modulus);
        accept = start && (state_reg == S_IDLE);

        // Next coefficient from the product the divider built alongside q
        c_new = c_prev_reg - mdi_pkg::coef_t'(div_rsp.prod);

        // On the last division the gcd and its coefficient are the values
        // held before the zero remainder: right after the reduction that is
        // the modulus itself with coefficient 0.
        if (state_reg == S_REDUCE)
        begin
            fin_r = r_prev_reg;
            fin_c = c_prev_reg;
        end
        else
        begin
            fin_r = r_cur_reg;
            fin_c = c_cur_reg;
        end
        // Fold a negative coefficient back into 0 .. modulus-1
        fin_fix = fin_c[mdi_pkg::WIDTH] ? (fin_c + mdi_pkg::coef_t'({1'b0, m_reg})) : fin_c;

        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        m_next      = m_reg;
        r_prev_next = r_prev_reg;
        r_cur_next  = r_cur_reg;
        c_prev_next = c_prev_reg;
        c_cur_next  = c_cur_reg;

        div_req          = '0;
        div_req.go       = 1'b0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mod_w < mdi_pkg::WIDTH'(2))
                    begin
                        // Answer a useless modulus at once
                        done_next               = 1'b1;
                        result_next.inverse_out = '0;
                        result_next.status      = mdi_pkg::ST_BAD_MODULUS;
                    end
                    else
                    begin
                        m_next           = mod_w;
                        r_prev_next      = mod_w;
                        c_prev_next      = '0;
                        c_cur_next       = mdi_pkg::coef_t'(1);
                        div_req.go       = 1'b1;
                        div_req.dividend = val_w;
                        div_req.divisor  = mod_w;
                        div_req.coef     = '0;
                        state_next       = S_REDUCE;
                    end
                end
            end

            S_REDUCE, S_ROUND:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem == '0)
                    begin
                        // Euclid ends: report the gcd test
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (fin_r == mdi_pkg::WIDTH'(1))
                        begin
                            result_next.inverse_out =
                                mdi_pkg::FIELD_W'(fin_fix[mdi_pkg::WIDTH-1:0]);
                            result_next.status      = mdi_pkg::ST_OK;
                        end
                        else
                        begin
                            result_next.inverse_out = '0;
                            result_next.status      = mdi_pkg::ST_NOT_COPRIME;
                        end
                    end
                    else
                    begin
                        // Advance one round and launch the next division
                        div_req.go      = 1'b1;
                        div_req.divisor = div_rsp.rem;
                        if (state_reg == S_REDUCE)
                        begin
                            r_cur_next       = div_rsp.rem;
                            div_req.dividend = r_prev_reg;
                            div_req.coef     = c_cur_reg;
                        end
                        else
                        begin
                            r_prev_next      = r_cur_reg;
                            r_cur_next       = div_rsp.rem;
                            c_prev_next      = c_cur_reg;
                            c_cur_next       = c_new;
                            div_req.dividend = r_cur_reg;
                            div_req.coef     = c_new;
                        end
                        state_next = S_ROUND;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        m_reg      <= m_next;
        r_prev_reg <= r_prev_next;
        r_cur_reg  <= r_cur_next;
        c_prev_reg <= c_prev_next;
        c_cur_reg  <= c_cur_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Error results always carry a zero inverse
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != mdi_pkg::ST_OK)) |-> (result.inverse_out == '0))
        else $error("error result with non-zero inverse");

    // A good inverse lies below the modulus
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == mdi_pkg::ST_OK))
            |-> (mdi_pkg::WIDTH'(result.inverse_out) < m_reg))
        else $error("inverse not reduced");

    // Never launch a division while the divider is still at work
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.go |-> !div_rsp.busy)
        else $error("divider launched while busy");

    // An accepted beat either starts work or is answered at once
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat dropped");

endmodule

`default_nettype wire
